### hdl/sofl_pkg.sv
`timescale 1ns / 1ps

package sofl_pkg;

  // Sizing of the slab and of the address path.
  localparam int MAX_OBJECTS  = 256;
  localparam int ADDRESS_BITS = 32;
  localparam int SIZE_W       = 16;
  localparam int OPS_W        = 9;
  localparam int IDX_W        = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int LINK_W       = $clog2(MAX_OBJECTS + 1);
  localparam int DIV_STEPS    = ADDRESS_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [1:0] REG_OBJECTS_PER_SLAB = 2'd0;
  localparam logic [1:0] REG_OBJECT_SIZE      = 2'd1;
  localparam logic [1:0] REG_OBJECT_BASE      = 2'd2;

  // Operation codes.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REBUILD = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  // Slab classes.
  localparam logic [1:0] CLASS_FULL    = 2'd0;
  localparam logic [1:0] CLASS_PARTIAL = 2'd1;
  localparam logic [1:0] CLASS_EMPTY   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_DIV,
    ST_DONE
  } state_t;

  // Request to the link table.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [LINK_W-1:0] wr_data;
    logic              clear;
  } lnk_req_t;

  // Divider result; quotient and remainder hold after done until the next start.
  typedef struct packed {
    logic                    done;
    logic [ADDRESS_BITS-1:0] quotient;
    logic [SIZE_W-1:0]       remainder;
  } div_res_t;

  // Object count clamped to 1..MAX_OBJECTS.
  function automatic logic [LINK_W-1:0] slab_count(input logic [OPS_W-1:0] ops);
    logic [LINK_W-1:0] n;
    if (ops == '0) begin
      n = LINK_W'(1);
    end else if (32'(ops) > MAX_OBJECTS) begin
      n = LINK_W'(MAX_OBJECTS);
    end else begin
      n = LINK_W'(ops);
    end
    return n;
  endfunction

  function automatic logic [1:0] class_of(input logic [LINK_W-1:0] used,
                                          input logic [LINK_W-1:0] n);
    logic [1:0] c;
    if (used >= n) begin
      c = CLASS_FULL;
    end else if (used == '0) begin
      c = CLASS_EMPTY;
    end else begin
      c = CLASS_PARTIAL;
    end
    return c;
  endfunction

endpackage

### hdl/sofl_ram.sv
`timescale 1ns / 1ps

module sofl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sofl_links.sv
`timescale 1ns / 1ps

module sofl_links (
  input  logic                      clk,
  input  logic                      rst,
  input  sofl_pkg::lnk_req_t        req,
  output logic [sofl_pkg::LINK_W-1:0] rd_data
);

  import sofl_pkg::*;

  // An entry whose valid bit is clear reads as its rebuilt value, index plus one.
  logic [MAX_OBJECTS-1:0] valid;
  logic                   rd_valid;
  logic [IDX_W-1:0]       rd_idx;
  logic [LINK_W-1:0]      ram_q;

  sofl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_OBJECTS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_idx),
    .wdata (req.wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_idx),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid <= valid[req.rd_idx];
      rd_idx   <= req.rd_idx;
    end
  end

  assign rd_data = rd_valid ? ram_q : (LINK_W'(rd_idx) + LINK_W'(1));

endmodule

### hdl/sofl_div.sv
`timescale 1ns / 1ps

module sofl_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [sofl_pkg::ADDRESS_BITS-1:0] dividend,
  input  logic [sofl_pkg::SIZE_W-1:0]       divisor,
  output sofl_pkg::div_res_t                res
);

  import sofl_pkg::*;

  // Restoring divider, one quotient bit per cycle.
  logic                    busy;
  logic                    done;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [ADDRESS_BITS-1:0] quo;
  logic [SIZE_W-1:0]       rem;
  logic [SIZE_W-1:0]       dsr;
  logic [SIZE_W:0]         rem_shift;
  logic [SIZE_W:0]         rem_sub;
  logic                    fits;

  always_comb begin
    rem_shift = {rem, quo[ADDRESS_BITS-1]};
    fits      = rem_shift >= {1'b0, dsr};
    rem_sub   = rem_shift - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == DIV_CNT_W'(DIV_STEPS - 1);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      quo <= {quo[ADDRESS_BITS-2:0], fits};
      rem <= fits ? rem_sub[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

### hdl/slab_object_free_list_core.sv
// Free-object chain of one slab. Each accepted request (allocate, free or
// reinitialize) gives exactly one result transfer carrying the status, the
// allocated address, the objects in use and the slab class with a class-change
// flag. The free objects form a chain of indices: a head register names the
// first free object and a link table in a synchronous RAM names the one after
// each object. A table entry that has not been written since reset or the last
// reinitialize reads as its own index plus one, which is tracked by one valid
// bit per entry, so reset and reinitialize finish at once with no clearing pass.
// The block works on one request at a time. An allocate goes through accept,
// link-table read and commit; a free of a plausible address waits before commit
// on the 32-step bit-serial divider that turns the address offset into an object
// index; reinitialize, unknown modes and rejected requests commit straight after
// accept. A new request is accepted as soon as the previous one has committed,
// even while its result still waits in the output register. Configuration
// writes take effect at once and belong to times when no request is in flight.
`timescale 1ns / 1ps

module slab_object_free_list_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [sofl_pkg::ADDRESS_BITS-1:0] cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        mode,
  input  logic [sofl_pkg::ADDRESS_BITS-1:0] free_address,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [sofl_pkg::ADDRESS_BITS-1:0] object_address,
  output logic [sofl_pkg::LINK_W-1:0]       objects_in_use,
  output logic [1:0]                        slab_class,
  output logic                              class_changed
);

  import sofl_pkg::*;

  // Configuration registers.
  logic [OPS_W-1:0]        objects_per_slab;
  logic [SIZE_W-1:0]       object_size;
  logic [ADDRESS_BITS-1:0] object_base;

  // Chain state.
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] count;

  // Values computed for the request in flight, committed together in ST_DONE.
  logic [1:0]              pend_status;
  logic [ADDRESS_BITS-1:0] pend_addr;
  logic [LINK_W-1:0]       pend_head;
  logic [LINK_W-1:0]       pend_count;
  logic                    pend_wr;
  logic [IDX_W-1:0]        pend_idx;
  logic                    pend_clear;

  state_t state;
  state_t state_next;

  logic                    accept;
  logic                    commit;
  logic                    div_start;
  logic [LINK_W-1:0]       slab_n;
  logic                    head_end;
  logic                    free_reject;
  logic [ADDRESS_BITS-1:0] free_offset;
  logic                    div_reject;
  logic [LINK_W-1:0]       link_data;
  logic [ADDRESS_BITS-1:0] alloc_addr;
  lnk_req_t                lnk_req;
  div_res_t                div_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      objects_per_slab <= OPS_W'(MAX_OBJECTS);
      object_size      <= SIZE_W'(32);
      object_base      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OBJECTS_PER_SLAB: objects_per_slab <= cfg_data[OPS_W-1:0];
        REG_OBJECT_SIZE:      object_size      <= cfg_data[SIZE_W-1:0];
        REG_OBJECT_BASE:      object_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode.
  assign slab_n      = slab_count(objects_per_slab);
  assign head_end    = head >= slab_n;
  assign free_offset = free_address - object_base;
  assign free_reject = (free_address < object_base) || (object_size == '0) || (count == '0);

  // After division: the offset must be an exact multiple and the index in the slab.
  assign div_reject = (div_res.remainder != '0) ||
                      (div_res.quotient >= ADDRESS_BITS'(slab_n));

  // Address of the head object; head is below the object count here.
  assign alloc_addr = object_base +
                      ADDRESS_BITS'(head[IDX_W-1:0]) * ADDRESS_BITS'(object_size);

  sofl_links u_links (
    .clk     (clk),
    .rst     (rst),
    .req     (lnk_req),
    .rd_data (link_data)
  );

  sofl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (free_offset),
    .divisor  (object_size),
    .res      (div_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_ALLOC && !head_end) begin
            state_next = ST_LINK;
          end else if (mode == MODE_FREE && !free_reject) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LINK: state_next = ST_DONE;
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    lnk_req   = '0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        lnk_req.rd_en  = in_valid && mode == MODE_ALLOC && !head_end;
        lnk_req.rd_idx = head[IDX_W-1:0];
        div_start      = in_valid && mode == MODE_FREE && !free_reject;
      end
      ST_DONE: begin
        commit          = !out_valid || out_ready;
        lnk_req.wr_en   = commit && pend_wr;
        lnk_req.wr_idx  = pend_idx;
        lnk_req.wr_data = head;
        lnk_req.clear   = commit && pend_clear;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Work out the effect of the request. A reinitialize empties the chain; an
  // allocate on an exhausted chain, a free that fails the early checks and an
  // unknown mode are settled here, the rest finish in ST_LINK or ST_DIV.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= (mode == MODE_ALLOC && head_end)   ? STAT_NO_FREE :
                     (mode == MODE_FREE && free_reject) ? STAT_BAD : STAT_OK;
      pend_addr   <= '0;
      pend_head   <= (mode == MODE_REBUILD) ? '0 : head;
      pend_count  <= (mode == MODE_REBUILD) ? '0 : count;
      pend_wr     <= 1'b0;
      pend_clear  <= mode == MODE_REBUILD;
    end else if (state == ST_LINK) begin
      pend_head  <= link_data;
      pend_addr  <= alloc_addr;
      pend_count <= (count < slab_n) ? count + LINK_W'(1) : count;
    end else if (state == ST_DIV && div_res.done) begin
      if (div_reject) begin
        pend_status <= STAT_BAD;
      end else begin
        pend_wr    <= 1'b1;
        pend_idx   <= div_res.quotient[IDX_W-1:0];
        pend_head  <= LINK_W'(div_res.quotient[IDX_W-1:0]);
        pend_count <= count - LINK_W'(1);
      end
    end
  end

  // Commit the chain state; the freed object's link gets the old head.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (commit) begin
      head  <= pend_head;
      count <= pend_count;
    end
  end

  // Output register; a finished result waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= pend_status;
      object_address <= pend_addr;
      objects_in_use <= pend_count;
      slab_class     <= class_of(pend_count, slab_n);
      class_changed  <= class_of(pend_count, slab_n) != class_of(count, slab_n);
    end
  end

`ifndef SYNTHESIS
  // Growing only below the clamped object count, in-use stays within MAX_OBJECTS.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_OBJECTS)
    else $error("objects in use exceed the slab capacity");

  // The divider only finishes for a free that is waiting on it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside a free");

  // A failed allocate reports no address.
  a_no_free_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NO_FREE |-> object_address == '0)
    else $error("address reported with no free object");

  // A committed request always presents its result in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed result not presented");
`endif

endmodule

### tb/slab_object_free_list_core_test.sv
`timescale 1ns / 1ps

module slab_object_free_list_core_test;
  import sofl_pkg::*;

  // Mode 3 is not an operation; the block must answer it with a plain OK and
  // leave its state alone. Register index 3 is likewise not a register.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  // The receiver's long hold-off, in cycles, and the number of cycles without
  // any transfer after which the run is declared hung. The limit leaves a wide
  // margin over a free and the random idle gaps of both sides, even around the
  // long hold-off.
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  // Everything one result transfer carries.
  typedef struct packed {
    logic [1:0]              status;
    logic [ADDRESS_BITS-1:0] address;
    logic [LINK_W-1:0]       in_use;
    logic [1:0]              cls;
    logic                    changed;
  } slab_result_t;

  // Tracks the free chain of the slab and the results it should produce.
  class free_chain_tracker;
    logic [LINK_W-1:0]       link_tbl [MAX_OBJECTS];
    logic [LINK_W-1:0]       head;
    logic [LINK_W-1:0]       used;
    logic [OPS_W-1:0]        ops_reg;
    logic [SIZE_W-1:0]       size_reg;
    logic [ADDRESS_BITS-1:0] base_reg;
    // Objects handed out and not yet returned; only steers stimulus.
    bit                      taken [MAX_OBJECTS];
    slab_result_t            pending_results [$];
    int                      errors;

    function new();
      clear_chain();
      ops_reg  = 9'd256;
      size_reg = 16'd32;
      base_reg = '0;
      errors   = 0;
    endfunction

    function void clear_chain();
      foreach (link_tbl[i]) link_tbl[i] = LINK_W'(i + 1);
      foreach (taken[i]) taken[i] = 1'b0;
      head = '0;
      used = '0;
    endfunction

    // Number of objects, with the register clamped into 1..MAX_OBJECTS.
    function int unsigned count();
      if (ops_reg == '0) return 1;
      if (ops_reg > MAX_OBJECTS) return MAX_OBJECTS;
      return ops_reg;
    endfunction

    function logic [1:0] class_for(int unsigned in_use, int unsigned n);
      if (in_use >= n) return CLASS_FULL;
      if (in_use == 0) return CLASS_EMPTY;
      return CLASS_PARTIAL;
    endfunction

    function void write_reg(logic [1:0] idx, logic [ADDRESS_BITS-1:0] data);
      case (idx)
        REG_OBJECTS_PER_SLAB: ops_reg = data[OPS_W-1:0];
        REG_OBJECT_SIZE:      size_reg = data[SIZE_W-1:0];
        REG_OBJECT_BASE:      base_reg = data;
        default: ;
      endcase
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(logic [1:0] op, logic [ADDRESS_BITS-1:0] addr);
      int unsigned     n;
      int unsigned     slot;
      longint unsigned off;
      longint unsigned idx;
      logic [1:0]      class_before;
      slab_result_t    r;
      n = count();
      class_before = class_for(used, n);
      r = '0;
      r.status = STAT_OK;
      case (op)
        MODE_ALLOC: begin
          if (head >= n) begin
            r.status = STAT_NO_FREE;
          end else begin
            slot = head;
            r.address = ADDRESS_BITS'(64'(base_reg) + 64'(slot) * 64'(size_reg));
            head = link_tbl[slot];
            if (used < n) used = used + 1'b1;
            taken[slot] = 1'b1;
          end
        end
        MODE_FREE: begin
          if (addr < base_reg || size_reg == '0 || used == '0) begin
            r.status = STAT_BAD;
          end else begin
            off = 64'(addr) - 64'(base_reg);
            idx = off / size_reg;
            if (off % size_reg != 0 || idx >= n) begin
              r.status = STAT_BAD;
            end else begin
              link_tbl[idx] = head;
              head = LINK_W'(idx);
              used = used - 1'b1;
              taken[idx] = 1'b0;
            end
          end
        end
        MODE_REBUILD: clear_chain();
        default: ;
      endcase
      r.in_use  = used;
      r.cls     = class_for(used, n);
      r.changed = (r.cls != class_before);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(slab_result_t got);
      slab_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, expected none, actual %0h",
                 $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("object_address", want.address, got.address);
      compare_field("objects_in_use", 32'(want.in_use), 32'(got.in_use));
      compare_field("slab_class", 32'(want.cls), 32'(got.cls));
      compare_field("class_changed", 32'(want.changed), 32'(got.changed));
    endfunction

    function int backlog();
      return pending_results.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [1:0]              cfg_index;
  logic [ADDRESS_BITS-1:0] cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              mode;
  logic [ADDRESS_BITS-1:0] free_address;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              status;
  logic [ADDRESS_BITS-1:0] object_address;
  logic [LINK_W-1:0]       objects_in_use;
  logic [1:0]              slab_class;
  logic                    class_changed;

  free_chain_tracker tracker;

  // Set by the stimulus to shape how the two sides idle: quiet turns idling off
  // on both sides, and hold_long makes the receiver take its long hold-off before
  // its next result.
  bit quiet;
  bit hold_long;
  int idle_cycles;

  slab_object_free_list_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .free_address   (free_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .object_address (object_address),
    .objects_in_use (objects_in_use),
    .slab_class     (slab_class),
    .class_changed  (class_changed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one request after a random gap (none if eager or quiet); returns at the
  // rising edge of its transfer. Valid is left high on return; the next call, or a
  // drain, decides at the following falling edge whether it stays high.
  task automatic offer(input logic [1:0] op, input logic [ADDRESS_BITS-1:0] addr,
                       input bit eager);
    int gap;
    gap = (eager || quiet) ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= op;
    free_address <= addr;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, addr);
  endtask

  // Stops offering and waits until every expected result has been transferred.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.backlog() != 0) @(posedge clk);
  endtask

  // Writes all registers while the block is idle. Bits above each register's
  // width carry random junk, which the block must drop. The write to the
  // unused index must change nothing.
  task automatic configure(input logic [OPS_W-1:0] ops, input logic [SIZE_W-1:0] size,
                           input logic [ADDRESS_BITS-1:0] base);
    logic [1:0]              idx  [4];
    logic [ADDRESS_BITS-1:0] data [4];
    drain_results();
    idx[0]  = REG_OBJECTS_PER_SLAB;
    data[0] = ($urandom & ~32'h1FF) | 32'(ops);
    idx[1]  = REG_OBJECT_SIZE;
    data[1] = ($urandom & ~32'hFFFF) | 32'(size);
    idx[2]  = REG_OBJECT_BASE;
    data[2] = base;
    idx[3]  = REG_UNUSED;
    data[3] = $urandom;
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= data[k];
      @(posedge clk);
      tracker.write_reg(idx[k], data[k]);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Draws one random request from the current state of the slab. Allocates
  // are favored while the slab is less than half used, so runs reach the full
  // class as well as the empty one. Most frees return an object that is out,
  // the rest are double frees, misaligned offsets, indexes past the end,
  // addresses below the base and plain noise.
  task automatic pick_request(output logic [1:0] op, output logic [ADDRESS_BITS-1:0] addr);
    int unsigned n;
    int unsigned roll;
    int unsigned start;
    int unsigned slot;
    int unsigned size;
    int unsigned base;
    int unsigned alloc_cut;
    bit          found;
    n    = tracker.count();
    size = tracker.size_reg;
    base = tracker.base_reg;
    addr = $urandom;
    alloc_cut = (2 * tracker.used < n) ? 55 : 40;
    roll = $urandom_range(0, 99);
    if (roll < alloc_cut) op = MODE_ALLOC;
    else if (roll < 94) op = MODE_FREE;
    else if (roll < 97) op = MODE_REBUILD;
    else op = MODE_UNUSED;
    if (op == MODE_FREE) begin
      start = $urandom_range(0, n - 1);
      slot  = start;
      found = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (!found && tracker.taken[(start + j) % n]) begin
          found = 1'b1;
          slot  = (start + j) % n;
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        addr = ADDRESS_BITS'(64'(base) + 64'(slot) * 64'(size));
      end else if (roll < 68) begin
        addr = ADDRESS_BITS'(64'(base) + 64'(start) * 64'(size));
      end else if (roll < 76) begin
        addr = ADDRESS_BITS'(64'(base) + 64'(slot) * 64'(size)
                             + ((size > 1) ? $urandom_range(1, size - 1) : 1));
      end else if (roll < 84) begin
        addr = ADDRESS_BITS'(64'(base) + 64'(n + $urandom_range(0, 7)) * 64'(size));
      end else if (roll < 92 && base > 0) begin
        addr = $urandom_range(0, base - 1);
      end
    end
  endtask

  task automatic random_requests(input int total);
    logic [1:0]              op;
    logic [ADDRESS_BITS-1:0] addr;
    repeat (total) begin
      pick_request(op, addr);
      offer(op, addr, 1'b0);
    end
  endtask

  // Result side: random stalls before each transfer, none while quiet, and one
  // long hold-off when asked for. Outputs are sampled at the rising edge.
  initial begin : result_sink
    int           stall;
    slab_result_t got;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        stall = LONG_HOLD;
        hold_long = 1'b0;
      end else if (quiet) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 10);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status  = status;
      got.address = object_address;
      got.in_use  = objects_in_use;
      got.cls     = slab_class;
      got.changed = class_changed;
      tracker.check_result(got);
    end
  end

  // Any transfer, or a register write, counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_OBJECTS_PER_SLAB;
    cfg_data     = '0;
    in_valid     = 1'b0;
    mode         = MODE_ALLOC;
    free_address = '0;
    out_ready    = 1'b0;
    quiet        = 1'b0;
    hold_long    = 1'b0;
    idle_cycles  = 0;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: 256 objects of 32 bytes at address zero. A free pushes
    // its object back on the head, so the next allocate returns it again.
    offer(MODE_ALLOC, 32'hFFFF_FFFF, 1'b0);
    offer(MODE_ALLOC, 32'h0, 1'b0);
    offer(MODE_ALLOC, $urandom, 1'b0);
    offer(MODE_FREE, 32'd32, 1'b0);
    offer(MODE_ALLOC, $urandom, 1'b0);
    offer(MODE_FREE, 32'd33, 1'b0);           // misaligned
    offer(MODE_FREE, 32'd8192, 1'b0);         // one past the last object
    offer(MODE_FREE, 32'hFFFF_FFFF, 1'b0);
    offer(MODE_UNUSED, $urandom, 1'b0);
    offer(MODE_REBUILD, $urandom, 1'b0);
    offer(MODE_FREE, 32'h0, 1'b0);            // nothing is in use
    offer(MODE_ALLOC, $urandom, 1'b0);

    // A single object at the top of the address space, one byte long. The count of
    // one carried over makes it full, so both allocates find no free object.
    configure(9'd1, 16'd1, 32'hFFFF_FFFF);
    offer(MODE_ALLOC, $urandom, 1'b0);
    offer(MODE_ALLOC, $urandom, 1'b0);
    offer(MODE_FREE, 32'h0, 1'b0);            // below the base
    offer(MODE_FREE, 32'hFFFF_FFFF, 1'b0);
    offer(MODE_FREE, 32'hFFFF_FFFF, 1'b0);    // already back, count is zero
    offer(MODE_ALLOC, $urandom, 1'b0);

    // A zero object count clamps to one, and a zero size rejects every free.
    configure(9'd0, 16'd0, 32'h0);
    offer(MODE_FREE, 32'h0, 1'b0);
    offer(MODE_ALLOC, $urandom, 1'b0);
    offer(MODE_REBUILD, $urandom, 1'b0);
    offer(MODE_ALLOC, $urandom, 1'b0);

    // Random phases. State carries over from one setting to the next, so
    // shrinking the slab leaves counts and chain heads past its end.
    configure(9'd8, 16'd24, 32'h1000_0000);
    quiet = 1'b1;
    random_requests(60);
    quiet = 1'b0;

    // 511 clamps to the largest slab. The receiver holds off for a long time
    // while allocates keep coming, so the block fills and stalls its input.
    configure(9'd511, 16'hFFFF, 32'hFFFF_0000);
    hold_long = 1'b1;
    repeat (12) offer(MODE_ALLOC, $urandom, 1'b1);
    random_requests(50);

    configure(9'd0, 16'd1, $urandom);
    random_requests(60);
    configure(9'd3, 16'd0, $urandom);
    random_requests(60);
    configure(OPS_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 65535)), $urandom);
    random_requests(60);
    // Allocated addresses wrap past the top of the address space here.
    configure(9'd256, 16'd1, 32'hFFFF_FF80);
    random_requests(60);
    configure(OPS_W'($urandom_range(1, 300)), SIZE_W'($urandom_range(1, 65535)), $urandom);
    random_requests(60);

    drain_results();
    repeat (60) @(posedge clk);
    if (tracker.errors == 0 && tracker.backlog() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sofl_pkg.sv
hdl/sofl_ram.sv
hdl/sofl_links.sv
hdl/sofl_div.sv
hdl/slab_object_free_list_core.sv
tb/slab_object_free_list_core_test.sv
